// ===== hw/rtl/swrm_pkg.sv =====
package swrm_pkg;

  localparam int RING_DEPTH_DEF = 1200;
  localparam int MAX_WINDOW_DEF = 60;

  localparam int TICK_W = 16;
  localparam int NS_W   = 40;
  localparam int WIN_W  = 8;
  localparam int Q_W    = 48;
  localparam int CNT_W  = 11;

  // sums over at most 2048 frames
  localparam int TSUM_W = TICK_W + 11;
  localparam int NSUM_W = NS_W + 11;

  // divider operands: ticks * 1e9 fits in 57 bits, busy sum in 51 bits
  localparam int DIV_W  = 64;

  localparam logic [29:0] NS_PER_S  = 30'd1000000000;
  localparam logic [19:0] NS_PER_MS = 20'd1000000;

  localparam logic [Q_W-1:0] Q_MAX = {Q_W{1'b1}};

  localparam logic CMD_PUSH  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic             go;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic           done;
    logic [Q_W-1:0] quot;
  } div_rsp_t;

endpackage

// ===== hw/rtl/sliding_window_rate_monitor.sv =====
// Sliding window rate monitor. A push (in_cmd = 0) stores one frame in a ring memory and
// gives no result. A query (in_cmd = 1) walks the stored frames newest first, reading
// each frame from memory and then accumulating it, until all are used or the next frame
// would push the summed wall time past the window; it then runs two bit-serial divisions
// on one shared divider. The ring holds RING_DEPTH frames, 1200 by default.
// A query on an empty ring skips the walk and the divisions. The result shows for
// exactly one cycle with out_valid and cannot be held off; busy drops in that same cycle.
module sliding_window_rate_monitor #(
  parameter int RING_DEPTH         = swrm_pkg::RING_DEPTH_DEF,
  parameter int MAX_WINDOW_SECONDS = swrm_pkg::MAX_WINDOW_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_cmd,
  input  logic [swrm_pkg::TICK_W-1:0] in_frame_ticks,
  input  logic [swrm_pkg::NS_W-1:0]   in_frame_busy_ns,
  input  logic [swrm_pkg::NS_W-1:0]   in_frame_wall_ns,
  input  logic [swrm_pkg::WIN_W-1:0]  in_window_seconds,
  output logic                        out_valid,
  output logic [swrm_pkg::Q_W-1:0]    out_tps_q16,
  output logic [swrm_pkg::Q_W-1:0]    out_mspt_q16,
  output logic                        out_tps_valid,
  output logic                        out_mspt_valid,
  output logic [swrm_pkg::CNT_W-1:0]  out_frames_used
);

  localparam int AW  = $clog2(RING_DEPTH);
  localparam int ENT = swrm_pkg::TICK_W + 2 * swrm_pkg::NS_W;
  localparam int LW  = 40;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_ACC, S_TPS, S_TPS_W, S_MSPT, S_MSPT_W, S_OUT
  } state_t;

  state_t state_r;

  logic [ENT-1:0] mem [RING_DEPTH];
  logic [ENT-1:0] rd_data_r;
  logic [AW-1:0]  rd_addr;
  logic           mem_we;

  logic [AW-1:0]                 wpos_r;
  logic [swrm_pkg::CNT_W-1:0]    count_r;
  logic [AW-1:0]                 idx_r;
  logic [swrm_pkg::CNT_W-1:0]    used_r;
  logic [swrm_pkg::TSUM_W-1:0]   ticks_r;
  logic [swrm_pkg::NSUM_W-1:0]   busy_r;
  logic [swrm_pkg::NSUM_W-1:0]   wall_r;
  logic [LW-1:0]                 limit_r;
  logic [swrm_pkg::Q_W-1:0]      tps_r;
  logic [swrm_pkg::Q_W-1:0]      mspt_r;
  logic                          qflag_r;

  swrm_pkg::div_req_t dreq;
  swrm_pkg::div_rsp_t drsp;

  logic [swrm_pkg::WIN_W-1:0]  ws;
  logic [swrm_pkg::TICK_W-1:0] e_ticks;
  logic [swrm_pkg::NS_W-1:0]   e_busy;
  logic [swrm_pkg::NS_W-1:0]   e_wall;
  logic [swrm_pkg::NSUM_W:0]   wall_try;
  logic                        take;
  logic                        accept;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);
  assign mem_we = accept && (in_cmd == swrm_pkg::CMD_PUSH);
  assign rd_addr = idx_r;

  always_ff @(posedge clk) begin
    if (mem_we) mem[wpos_r] <= {in_frame_ticks, in_frame_busy_ns, in_frame_wall_ns};
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    if (in_window_seconds == '0) ws = swrm_pkg::WIN_W'(1);
    else if (in_window_seconds > swrm_pkg::WIN_W'(MAX_WINDOW_SECONDS))
      ws = swrm_pkg::WIN_W'(MAX_WINDOW_SECONDS);
    else ws = in_window_seconds;
    {e_ticks, e_busy, e_wall} = rd_data_r;
    wall_try = {1'b0, wall_r} + (swrm_pkg::NSUM_W + 1)'(e_wall);
    take = (used_r == '0) || (wall_try <= (swrm_pkg::NSUM_W + 1)'(limit_r));
    dreq = '0;
    if (state_r == S_TPS) begin
      dreq.go  = 1'b1;
      dreq.num = swrm_pkg::DIV_W'(ticks_r) * swrm_pkg::DIV_W'(swrm_pkg::NS_PER_S);
      dreq.den = swrm_pkg::DIV_W'(wall_r);
    end else if (state_r == S_MSPT) begin
      dreq.go  = 1'b1;
      dreq.num = swrm_pkg::DIV_W'(busy_r);
      dreq.den = swrm_pkg::DIV_W'(ticks_r) * swrm_pkg::DIV_W'(swrm_pkg::NS_PER_MS);
    end
  end

  swrm_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      wpos_r    <= '0;
      count_r   <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_cmd == swrm_pkg::CMD_PUSH) begin
              wpos_r <= (wpos_r == AW'(RING_DEPTH - 1)) ? '0 : wpos_r + 1'b1;
              if (count_r < swrm_pkg::CNT_W'(RING_DEPTH)) count_r <= count_r + 1'b1;
              state_r <= S_OUT;
            end else begin
              idx_r   <= (wpos_r == '0) ? AW'(RING_DEPTH - 1) : wpos_r - 1'b1;
              used_r  <= '0;
              ticks_r <= '0;
              busy_r  <= '0;
              wall_r  <= '0;
              tps_r   <= '0;
              mspt_r  <= '0;
              limit_r <= LW'(ws) * LW'(swrm_pkg::NS_PER_S);
              state_r <= (count_r == '0) ? S_OUT : S_READ;
            end
          end
        end
        S_READ: state_r <= S_ACC;
        S_ACC: begin
          if (take) begin
            ticks_r <= ticks_r + swrm_pkg::TSUM_W'(e_ticks);
            busy_r  <= busy_r + swrm_pkg::NSUM_W'(e_busy);
            wall_r  <= wall_try[swrm_pkg::NSUM_W-1:0];
            used_r  <= used_r + 1'b1;
            idx_r   <= (idx_r == '0) ? AW'(RING_DEPTH - 1) : idx_r - 1'b1;
            state_r <= (used_r + 1'b1 == count_r) ? S_TPS : S_READ;
          end else begin
            state_r <= S_TPS;
          end
        end
        S_TPS:    state_r <= S_TPS_W;
        S_TPS_W:  if (drsp.done) begin
          tps_r   <= (wall_r != '0) ? drsp.quot : '0;
          state_r <= S_MSPT;
        end
        S_MSPT:   state_r <= S_MSPT_W;
        S_MSPT_W: if (drsp.done) begin
          mspt_r  <= (ticks_r != '0) ? drsp.quot : '0;
          out_valid <= 1'b1;
          state_r <= S_IDLE;
        end
        S_OUT: begin
          out_valid <= qflag_r;
          state_r   <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // remembers whether S_OUT serves an empty query rather than a push
  always_ff @(posedge clk) begin
    if (!rst_n) qflag_r <= 1'b0;
    else if (accept) qflag_r <= (in_cmd == swrm_pkg::CMD_QUERY);
  end

  assign out_tps_q16     = tps_r;
  assign out_mspt_q16    = mspt_r;
  assign out_tps_valid   = (used_r != '0) && (wall_r != '0);
  assign out_mspt_valid  = (used_r != '0) && (ticks_r != '0);
  assign out_frames_used = used_r;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result without work");
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_frames_used <= count_r) else $error("too many frames");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= swrm_pkg::CNT_W'(RING_DEPTH)) else $error("count overflow");

endmodule

// ===== hw/rtl/swrm_div.sv =====
module swrm_div (
  input  logic              clk,
  input  logic              rst_n,
  input  swrm_pkg::div_req_t req,
  output swrm_pkg::div_rsp_t rsp
);

  // restoring division producing floor(num * 2^16 / den), one bit a cycle
  localparam int QB = swrm_pkg::DIV_W + 16;
  localparam int STEP_W = $clog2(QB + 1);

  logic [QB-1:0]                 num_r;
  logic [swrm_pkg::DIV_W:0]      rem_r;
  logic [swrm_pkg::DIV_W-1:0]    den_r;
  logic [STEP_W-1:0]             step_r;
  logic                          run_r;
  logic                          done_r;

  logic [swrm_pkg::DIV_W+1:0] trial;
  logic [swrm_pkg::DIV_W:0]   shifted;

  always_comb begin
    shifted = {rem_r[swrm_pkg::DIV_W-1:0], num_r[QB-1]};
    trial   = {1'b0, shifted} - {2'b00, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        num_r  <= {req.num, 16'd0};
        den_r  <= req.den;
        rem_r  <= '0;
        step_r <= STEP_W'(QB);
        run_r  <= 1'b1;
      end else if (run_r) begin
        if (!trial[swrm_pkg::DIV_W+1]) begin
          rem_r <= trial[swrm_pkg::DIV_W:0];
          num_r <= {num_r[QB-2:0], 1'b1};
        end else begin
          rem_r <= shifted;
          num_r <= {num_r[QB-2:0], 1'b0};
        end
        step_r <= step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // integer part beyond 32 bits saturates
  assign rsp.done = done_r;
  assign rsp.quot = (|num_r[QB-1:48]) ? swrm_pkg::Q_MAX : num_r[47:0];

endmodule
